### src/mecanum_wheel_speed_mixer_macros.svh
// Assertion macros shared by the mecanum wheel speed mixer RTL.
`ifndef MECANUM_WHEEL_SPEED_MIXER_MACROS_SVH
`define MECANUM_WHEEL_SPEED_MIXER_MACROS_SVH

// Whenever cond holds, prop must hold in the same cycle.
`define MWSM_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("mwsm: same-cycle check failed");

// Whenever cond holds, prop must hold in the next cycle.
`define MWSM_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("mwsm: next-cycle check failed");

`endif

### src/mwsm_pkg.sv
// Shared constants and types for the mecanum wheel speed mixer.
package mwsm_pkg;

  // Field widths of the command and wheel channels.
  localparam int MODE_W    = 2;
  localparam int SPEED_W   = 16;
  localparam int ANGLE_W   = 15;
  localparam int WHEEL_W   = 18;
  localparam int SINE_W    = 16;
  localparam int SINE_MAG_W = 15;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 15;
  localparam int SPIN_RATE_W = 15;
  localparam int GAIN_W      = 8;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Drive modes.
  localparam mode_t MODE_NO_FORCE = 2'd0;
  localparam mode_t MODE_FOLLOW   = 2'd1;
  localparam mode_t MODE_ROTATE   = 2'd2;
  localparam mode_t MODE_OTHER    = 2'd3;

  // Register indexes.
  localparam cfg_index_t REG_SPIN_RATE   = 1'd0;
  localparam cfg_index_t REG_FOLLOW_GAIN = 1'd1;

  // Register reset values.
  localparam logic [SPIN_RATE_W-1:0] SPIN_RATE_RESET   = 15'd1200;
  localparam logic [GAIN_W-1:0]      FOLLOW_GAIN_RESET = 8'd3;

  // Angle constants in Q2.30.
  localparam logic [63:0] PI_Q30          = 64'd3373259426;
  localparam logic [63:0] TWO_OVER_PI_Q30 = 64'd683565276;
  localparam logic [63:0] ONE_Q30         = 64'd1073741824;

  // Largest angle magnitude that a 15-bit signed angle can carry.
  localparam int MAG_W   = 15;
  localparam int MAG_MAX = 16384;

  // Taylor series of the sine: divisor (2i)(2i+1) for term i.
  localparam int TAYLOR_TERMS = 10;
  localparam logic [63:0] TAYLOR_DIV [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

endpackage

### src/mwsm_cmd_if.sv
// Chassis command channel: drive mode, speeds and gimbal offset angle.
interface mwsm_cmd_if;
  logic                                  valid;
  logic                                  ready;
  mwsm_pkg::mode_t                       mode;
  logic signed [mwsm_pkg::SPEED_W-1:0]   speed_x;
  logic signed [mwsm_pkg::SPEED_W-1:0]   speed_y;
  logic signed [mwsm_pkg::ANGLE_W-1:0]   gimbal_angle;

  modport source (output valid, mode, speed_x, speed_y, gimbal_angle, input ready);
  modport sink (input valid, mode, speed_x, speed_y, gimbal_angle, output ready);
endinterface

### src/mwsm_wheel_if.sv
// Wheel target channel: four wheel speeds and the motor enable flag.
interface mwsm_wheel_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mwsm_pkg::WHEEL_W-1:0]   front_left_speed;
  logic signed [mwsm_pkg::WHEEL_W-1:0]   right_front_speed;
  logic signed [mwsm_pkg::WHEEL_W-1:0]   left_back_speed;
  logic signed [mwsm_pkg::WHEEL_W-1:0]   right_back_speed;
  logic                                  motors_enabled;

  modport source (output valid, front_left_speed, right_front_speed, left_back_speed,
                  right_back_speed, motors_enabled, input ready);
  modport sink (input valid, front_left_speed, right_front_speed, left_back_speed,
                right_back_speed, motors_enabled, output ready);
endinterface

### src/mecanum_wheel_speed_mixer.sv
// Mecanum wheel speed mixer: eight-stage pipeline that turns one chassis command into
// four wheel speed targets. The command speeds are rotated by the gimbal offset angle
// (sine and cosine from a quarter-wave table), a spin term chosen by the mode is mixed
// in, and the four targets leave in the order front left, right front, left back,
// right back, with motors_enabled clear in no-force mode. A command can be taken every
// clock cycle unless a stall on the output has backed up to the first stage. Each stage
// holds one command and moves on as soon as the stage after it is free, so a stalled
// output only stops the commands behind it and empty stages still fill. The longest
// paths are the angle to phase multiply, the constant divide by the table depth and
// the four rotation multipliers, each in a stage of its own. spin_rate and
// follow_gain are to be written over the configuration port only while no command is
// in flight; the block itself does not enforce this.
`include "mecanum_wheel_speed_mixer_macros.svh"

module mecanum_wheel_speed_mixer #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int ANGLE_FRAC_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mwsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mwsm_pkg::CFG_DATA_W-1:0]     cfg_data,
  mwsm_cmd_if.sink                            cmd,
  mwsm_wheel_if.source                        wheels
);

  localparam int STAGES  = 8;
  localparam int MAG_W   = mwsm_pkg::MAG_W;
  localparam int WHEEL_W = mwsm_pkg::WHEEL_W;
  localparam int SPEED_W = mwsm_pkg::SPEED_W;
  localparam int SINE_W  = mwsm_pkg::SINE_W;
  localparam int SMAG_W  = mwsm_pkg::SINE_MAG_W;

  // Phase scale: table depth times two over pi (table entries per radian), in Q30.
  localparam logic [63:0] K_PHASE = 64'(SINE_TABLE_DEPTH) * mwsm_pkg::TWO_OVER_PI_Q30;
  localparam int K_W      = $clog2(K_PHASE + 64'd1);
  localparam int K_SPLIT  = 21;
  localparam int KH_W     = K_W - K_SPLIT;
  localparam logic [K_SPLIT-1:0] K_LO = K_PHASE[K_SPLIT-1:0];
  localparam logic [KH_W-1:0]    K_HI = KH_W'(K_PHASE >> K_SPLIT);
  localparam int PL_LO_W  = MAG_W + K_SPLIT;
  localparam int PL_HI_W  = MAG_W + KH_W;
  localparam int SH       = 30 + ANGLE_FRAC_BITS;
  localparam int PROD_W   = (MAG_W + K_W + 1 > SH + 1) ? MAG_W + K_W + 1 : SH + 1;
  localparam logic [PROD_W-1:0] ROUND_N = PROD_W'(64'd1 << (SH - 1));

  // Phase index range and its split into quadrant and table offset.
  localparam logic [63:0] N_MAX =
    (64'(mwsm_pkg::MAG_MAX) * K_PHASE + (64'd1 << (SH - 1))) >> SH;
  localparam int N_W      = (N_MAX > 64'd1) ? $clog2(N_MAX + 64'd1) : 1;
  localparam logic [63:0] Q_MAX = N_MAX / SINE_TABLE_DEPTH;
  localparam int Q_RAW_W  = $clog2(Q_MAX + 64'd1);
  localparam int Q_W      = (Q_RAW_W > 2) ? Q_RAW_W : 2;
  localparam int DEPTH_LOG = $clog2(SINE_TABLE_DEPTH);
  localparam int RS       = N_W + DEPTH_LOG;
  localparam logic [63:0] RECIP =
    ((64'd1 << RS) + 64'(SINE_TABLE_DEPTH) - 64'd1) / SINE_TABLE_DEPTH;
  localparam int M_W      = $clog2(RECIP + 64'd1);
  localparam int QP_W     = N_W + M_W;
  localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [N_W-1:0]   DEPTH_N   = N_W'(SINE_TABLE_DEPTH);
  localparam logic [63:0] TABLE_SPAN = 64'(2 * SINE_TABLE_DEPTH);

  // Follow-mode spin: gain times squared angle magnitude.
  localparam int MAG_SQ_W = 2 * MAG_W;
  localparam int FP_W     = mwsm_pkg::GAIN_W + MAG_SQ_W;
  localparam int SUM_W    = 2 * SPEED_W + 1;

  // Sine table entry k: round(32767 * sin(k*pi/(2*depth))) by Q30 Taylor series.
  function automatic logic [SMAG_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x = (64'(k) * mwsm_pkg::PI_Q30) / TABLE_SPAN;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int i = 1; i <= mwsm_pkg::TAYLOR_TERMS; i++) begin
      term = (term * x2) >> 30;
      term = term / mwsm_pkg::TAYLOR_DIV[i];
      if ((i & 1) != 0) begin
        sum = (term <= sum) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (mwsm_pkg::ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SMAG_W-1:0];
  endfunction

  // Constant quarter-wave table.
  logic [SMAG_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  // Configuration registers.
  logic [mwsm_pkg::SPIN_RATE_W-1:0] spin_rate;
  logic [mwsm_pkg::GAIN_W-1:0]      follow_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      spin_rate   <= mwsm_pkg::SPIN_RATE_RESET;
      follow_gain <= mwsm_pkg::FOLLOW_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwsm_pkg::REG_SPIN_RATE:   spin_rate   <= cfg_data[mwsm_pkg::SPIN_RATE_W-1:0];
        mwsm_pkg::REG_FOLLOW_GAIN: follow_gain <= cfg_data[mwsm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance: a stage loads when it is empty or its
  // contents move on in the same cycle.
  logic [STAGES:1]   valid;
  logic [STAGES+1:1] adv;

  always_comb begin
    adv[STAGES+1] = wheels.ready;
    for (int i = STAGES; i >= 1; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[1]) begin
        valid[1] <= cmd.valid;
      end
      for (int i = 2; i <= STAGES; i++) begin
        if (adv[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign cmd.ready = adv[1];

  // Stage 1: angle magnitude, phase partial products and squared magnitude.
  logic [MAG_W-1:0]             in_mag;
  logic                         s1_neg;
  mwsm_pkg::mode_t              s1_mode;
  logic signed [SPEED_W-1:0]    s1_vx, s1_vy;
  logic [PL_LO_W-1:0]           s1_pl_lo;
  logic [PL_HI_W-1:0]           s1_pl_hi;
  logic [MAG_SQ_W-1:0]          s1_mag_sq;

  assign in_mag = cmd.gimbal_angle[mwsm_pkg::ANGLE_W-1] ? MAG_W'(-cmd.gimbal_angle)
                                                        : MAG_W'(cmd.gimbal_angle);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_neg    <= cmd.gimbal_angle[mwsm_pkg::ANGLE_W-1];
      s1_mode   <= cmd.mode;
      s1_vx     <= cmd.speed_x;
      s1_vy     <= cmd.speed_y;
      s1_pl_lo  <= PL_LO_W'(in_mag) * PL_LO_W'(K_LO);
      s1_pl_hi  <= PL_HI_W'(in_mag) * PL_HI_W'(K_HI);
      s1_mag_sq <= MAG_SQ_W'(in_mag) * MAG_SQ_W'(in_mag);
    end
  end

  // Stage 2: rounded phase index and spin term.
  logic [PROD_W-1:0]          phase_full;
  logic [FP_W-1:0]            follow_prod;
  logic signed [WHEEL_W-1:0]  wz_sel;
  logic                       s2_neg, s2_en;
  logic signed [SPEED_W-1:0]  s2_vx, s2_vy;
  logic [N_W-1:0]             s2_n;
  logic signed [WHEEL_W-1:0]  s2_wz;

  assign phase_full = (PROD_W'(s1_pl_hi) << K_SPLIT) + PROD_W'(s1_pl_lo) + ROUND_N;
  assign follow_prod = FP_W'(follow_gain) * FP_W'(s1_mag_sq);

  always_comb begin
    case (s1_mode)
      mwsm_pkg::MODE_ROTATE: wz_sel = WHEEL_W'(spin_rate);
      mwsm_pkg::MODE_FOLLOW: wz_sel = -WHEEL_W'(follow_prod >> (2 * ANGLE_FRAC_BITS));
      default:               wz_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_neg <= s1_neg;
      s2_en  <= (s1_mode != mwsm_pkg::MODE_NO_FORCE);
      s2_vx  <= s1_vx;
      s2_vy  <= s1_vy;
      s2_n   <= N_W'(phase_full >> SH);
      s2_wz  <= wz_sel;
    end
  end

  // Stage 3: quadrant count by multiplying with the reciprocal of the depth.
  logic [QP_W-1:0]            quot_prod;
  logic                       s3_neg, s3_en;
  logic signed [SPEED_W-1:0]  s3_vx, s3_vy;
  logic [N_W-1:0]             s3_n;
  logic [Q_W-1:0]             s3_q;
  logic signed [WHEEL_W-1:0]  s3_wz;

  assign quot_prod = QP_W'(s2_n) * QP_W'(RECIP);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_neg <= s2_neg;
      s3_en  <= s2_en;
      s3_vx  <= s2_vx;
      s3_vy  <= s2_vy;
      s3_n   <= s2_n;
      s3_q   <= Q_W'(quot_prod >> RS);
      s3_wz  <= s2_wz;
    end
  end

  // Stage 4: offset within the quarter wave.
  logic [N_W-1:0]             rem_full;
  logic                       s4_neg, s4_en;
  logic signed [SPEED_W-1:0]  s4_vx, s4_vy;
  logic [1:0]                 s4_quad;
  logic [IDX_W-1:0]           s4_rem;
  logic signed [WHEEL_W-1:0]  s4_wz;

  assign rem_full = s3_n - N_W'(N_W'(s3_q) * DEPTH_N);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_neg  <= s3_neg;
      s4_en   <= s3_en;
      s4_vx   <= s3_vx;
      s4_vy   <= s3_vy;
      s4_quad <= s3_q[1:0];
      s4_rem  <= IDX_W'(rem_full);
      s4_wz   <= s3_wz;
    end
  end

  // Stage 5: table lookups; in odd quadrants the sine reads the table backwards, the cosine forwards.
  logic [IDX_W-1:0]           idx_fwd, idx_rev;
  logic [SMAG_W-1:0]          sin_mag, cos_mag;
  logic                       sin_neg, cos_neg;
  logic                       s5_en;
  logic signed [SPEED_W-1:0]  s5_vx, s5_vy;
  logic signed [SINE_W-1:0]   s5_sin, s5_cos;
  logic signed [WHEEL_W-1:0]  s5_wz;

  assign idx_fwd = s4_rem;
  assign idx_rev = DEPTH_IDX - s4_rem;
  assign sin_mag = s4_quad[0] ? sine_rom[idx_rev] : sine_rom[idx_fwd];
  assign cos_mag = s4_quad[0] ? sine_rom[idx_fwd] : sine_rom[idx_rev];
  assign sin_neg = s4_quad[1] ^ s4_neg;
  assign cos_neg = s4_quad[1] ^ s4_quad[0];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_en  <= s4_en;
      s5_vx  <= s4_vx;
      s5_vy  <= s4_vy;
      s5_sin <= sin_neg ? -SINE_W'(sin_mag) : SINE_W'(sin_mag);
      s5_cos <= cos_neg ? -SINE_W'(cos_mag) : SINE_W'(cos_mag);
      s5_wz  <= s4_wz;
    end
  end

  // Stage 6: rotation products.
  logic                              s6_en;
  logic signed [2*SPEED_W-1:0]       s6_xc, s6_ys, s6_yc, s6_xs;
  logic signed [WHEEL_W-1:0]         s6_wz;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_en <= s5_en;
      s6_xc <= s5_vx * s5_cos;
      s6_ys <= s5_vy * s5_sin;
      s6_yc <= s5_vy * s5_cos;
      s6_xs <= s5_vx * s5_sin;
      s6_wz <= s5_wz;
    end
  end

  // Stage 7: rotated speeds, rounded half up from Q15.
  logic signed [SUM_W-1:0]    sum_x, sum_y, rnd_x, rnd_y;
  logic                       s7_en;
  logic signed [WHEEL_W-1:0]  s7_rx, s7_ry, s7_wz;

  assign sum_x = SUM_W'(s6_xc) + SUM_W'(s6_ys);
  assign sum_y = SUM_W'(s6_yc) - SUM_W'(s6_xs);
  assign rnd_x = (sum_x + SUM_W'(16384)) >>> 15;
  assign rnd_y = (sum_y + SUM_W'(16384)) >>> 15;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_en <= s6_en;
      s7_rx <= rnd_x[WHEEL_W-1:0];
      s7_ry <= rnd_y[WHEEL_W-1:0];
      s7_wz <= s6_wz;
    end
  end

  // Stage 8: wheel mix, held in the output register until transferred.
  always_ff @(posedge clk) begin
    if (adv[8]) begin
      wheels.front_left_speed  <= s7_rx - s7_ry + s7_wz;
      wheels.right_front_speed <= s7_rx + s7_ry + s7_wz;
      wheels.left_back_speed   <= s7_rx + s7_ry - s7_wz;
      wheels.right_back_speed  <= s7_rx - s7_ry - s7_wz;
      wheels.motors_enabled    <= s7_en;
    end
  end

  assign wheels.valid = valid[STAGES];

  // An accepted command always occupies the first stage in the next cycle.
  `MWSM_ASSERT_NEXT(a_enter_stage1, clk, rst, cmd.valid && cmd.ready, valid[1])

  // The quarter-wave offset must stay below the table depth.
  `MWSM_ASSERT_SAME(a_rem_in_range, clk, rst, valid[4], s4_rem < DEPTH_IDX)

  // Front left plus left back and right front plus right back both equal twice rx.
  `MWSM_ASSERT_SAME(a_wheel_balance, clk, rst, wheels.valid,
    (wheels.front_left_speed + wheels.left_back_speed) ==
    (wheels.right_front_speed + wheels.right_back_speed))

endmodule

### dv/mwsm_wheel_checker.sv
// Checker for the wheel speed mixer: predicts the wheel targets of each command and compares.
`timescale 1ns / 1ps

module mwsm_wheel_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mwsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mwsm_pkg::CFG_DATA_W-1:0]  cfg_data,
  mwsm_cmd_if                              cmd,
  mwsm_wheel_if                            wheels,
  output int                               mismatches,
  output int                               outstanding
);

  localparam int SINE_DEPTH  = 256;
  localparam int ANGLE_FRAC  = 12;
  localparam int PHASE_SHIFT = 30 + ANGLE_FRAC;
  localparam int WHEEL_W     = mwsm_pkg::WHEEL_W;

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [WHEEL_W-1:0] front_left;
    logic signed [WHEEL_W-1:0] right_front;
    logic signed [WHEEL_W-1:0] left_back;
    logic signed [WHEEL_W-1:0] right_back;
    logic                      enabled;
  } wheel_targets_t;

  int                               quarter_sine [0:SINE_DEPTH];
  logic [mwsm_pkg::SPIN_RATE_W-1:0] spin_rate_q;
  logic [mwsm_pkg::GAIN_W-1:0]      follow_gain_q;
  wheel_targets_t                   wheel_targets_due [$];

  // Quarter-wave sine in Q1.15, from a Q2.30 Taylor series of eleven terms.
  initial begin : build_quarter_sine
    longint unsigned x, x2, term, sum, v;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x = (u64_t'(k) * mwsm_pkg::PI_Q30) / u64_t'(2 * SINE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int i = 1; i <= 10; i++) begin
        term = (term * x2) >> 30;
        term = term / u64_t'((2 * i) * (2 * i + 1));
        if (i % 2 == 1) begin
          sum = (term <= sum) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32767 + (mwsm_pkg::ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      quarter_sine[k] = int'(v);
    end
  end

  // Sine at a phase index, unfolded through the four quadrants.
  function automatic longint sine_at_phase(longint unsigned n);
    longint unsigned quadrant, rem;
    longint          v;
    quadrant = (n / SINE_DEPTH) % 4;
    rem = n % SINE_DEPTH;
    v = (quadrant[0] == 1'b0) ? quarter_sine[rem] : quarter_sine[SINE_DEPTH - rem];
    return (quadrant >= 2) ? -v : v;
  endfunction

  // Rotates the command speeds into the chassis frame and mixes in the spin.
  function automatic wheel_targets_t mix_wheel_targets(
      mwsm_pkg::mode_t mode,
      logic signed [mwsm_pkg::SPEED_W-1:0] vx,
      logic signed [mwsm_pkg::SPEED_W-1:0] vy,
      logic signed [mwsm_pkg::ANGLE_W-1:0] angle);
    longint          ang, sin_v, cos_v, rx, ry, wz;
    longint unsigned mag, phase, spin_product;
    wheel_targets_t  t;
    ang = angle;
    mag = (ang < 0) ? -ang : ang;
    phase = (mag * SINE_DEPTH * mwsm_pkg::TWO_OVER_PI_Q30 + (64'd1 << (PHASE_SHIFT - 1)))
            >> PHASE_SHIFT;
    sin_v = sine_at_phase(phase);
    cos_v = sine_at_phase(phase + SINE_DEPTH);
    if (ang < 0) begin
      sin_v = -sin_v;
    end
    // Round half up in Q15.
    rx = (longint'(vx) * cos_v + longint'(vy) * sin_v + 16384) >>> 15;
    ry = (longint'(vy) * cos_v - longint'(vx) * sin_v + 16384) >>> 15;
    spin_product = u64_t'(follow_gain_q) * mag * mag;
    case (mode)
      mwsm_pkg::MODE_ROTATE: wz = longint'(spin_rate_q);
      mwsm_pkg::MODE_FOLLOW: wz = -longint'(spin_product >> (2 * ANGLE_FRAC));
      default:               wz = 0;
    endcase
    t.front_left  = WHEEL_W'(rx - ry + wz);
    t.right_front = WHEEL_W'(rx + ry + wz);
    t.left_back   = WHEEL_W'(rx + ry - wz);
    t.right_back  = WHEEL_W'(rx - ry - wz);
    t.enabled     = (mode != mwsm_pkg::MODE_NO_FORCE);
    return t;
  endfunction

  task automatic check_field(input string name, input int want, input int got,
                             inout int bad);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad++;
    end
  endtask

  // Track register writes, predict each command transfer, compare each wheel transfer.
  always @(posedge clk) begin : track_transfers
    wheel_targets_t want;
    int             bad;
    bad = 0;
    if (rst) begin
      spin_rate_q   <= mwsm_pkg::SPIN_RATE_RESET;
      follow_gain_q <= mwsm_pkg::FOLLOW_GAIN_RESET;
      wheel_targets_due.delete();
      mismatches    <= 0;
      outstanding   <= 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        wheel_targets_due.push_back(mix_wheel_targets(cmd.mode, cmd.speed_x, cmd.speed_y,
                                                      cmd.gimbal_angle));
      end
      if (wheels.valid && wheels.ready) begin
        if (wheel_targets_due.size() == 0) begin
          $error("wheel targets transfer with no command waiting for it");
          bad++;
        end else begin
          want = wheel_targets_due.pop_front();
          check_field("front_left_speed", want.front_left, wheels.front_left_speed, bad);
          check_field("right_front_speed", want.right_front, wheels.right_front_speed, bad);
          check_field("left_back_speed", want.left_back, wheels.left_back_speed, bad);
          check_field("right_back_speed", want.right_back, wheels.right_back_speed, bad);
          check_field("motors_enabled", want.enabled, wheels.motors_enabled, bad);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          mwsm_pkg::REG_SPIN_RATE:
            spin_rate_q   <= cfg_data[mwsm_pkg::SPIN_RATE_W-1:0];
          mwsm_pkg::REG_FOLLOW_GAIN:
            follow_gain_q <= cfg_data[mwsm_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      mismatches  <= mismatches + bad;
      outstanding <= wheel_targets_due.size();
    end
  end

endmodule

### dv/tb_mecanum_wheel_speed_mixer.sv
// Top of the wheel speed mixer testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_mecanum_wheel_speed_mixer;

  localparam int RANDOM_PER_PHASE = 200;
  localparam int PHASES           = 6;
  localparam int DRAIN_CYCLES     = 24;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int STEADY_RUN       = 40;
  localparam int SPEED_W          = mwsm_pkg::SPEED_W;
  localparam int ANGLE_W          = mwsm_pkg::ANGLE_W;
  localparam int SPIN_RATE_W      = mwsm_pkg::SPIN_RATE_W;
  localparam int GAIN_W           = mwsm_pkg::GAIN_W;
  localparam int CFG_DATA_W       = mwsm_pkg::CFG_DATA_W;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [mwsm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]            cfg_data;
  int                               mismatches;
  int                               outstanding;
  int                               cycles = 0;
  int                               commands_sent = 0;
  bit                               sender_steady = 1'b0;
  bit                               receiver_steady = 1'b0;

  mwsm_cmd_if   cmd();
  mwsm_wheel_if wheels();

  mecanum_wheel_speed_mixer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .wheels    (wheels)
  );

  mwsm_wheel_checker wheel_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .wheels      (wheels),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Wheel side: a random stall before each transfer, with runs of no stalls.
  initial begin : wheel_ready_driver
    int stall;
    int taken;
    taken = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (taken % STEADY_RUN == 0) begin
        receiver_steady = ($urandom_range(0, 3) == 0);
      end
      stall = receiver_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        wheels.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      wheels.ready <= 1'b1;
      do @(posedge clk); while (!wheels.valid);
      @(negedge clk);
      taken++;
    end
  end

  // One command transfer after a random gap; called and returns at a falling edge.
  task automatic send_command(input mwsm_pkg::mode_t m,
                              input logic signed [SPEED_W-1:0] vx,
                              input logic signed [SPEED_W-1:0] vy,
                              input logic signed [ANGLE_W-1:0] ang);
    int gap;
    if (commands_sent % STEADY_RUN == 0) begin
      sender_steady = ($urandom_range(0, 3) == 0);
    end
    gap = sender_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.mode         <= m;
    cmd.speed_x      <= vx;
    cmd.speed_y      <= vy;
    cmd.gimbal_angle <= ang;
    do @(posedge clk); while (!cmd.ready);
    @(negedge clk);
    commands_sent++;
  endtask

  // Holds commands back until every wheel target has come out.
  task automatic drain_pipeline();
    cmd.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Writes both registers on consecutive cycles.
  task automatic write_registers(input logic [SPIN_RATE_W-1:0] spin,
                                 input logic [GAIN_W-1:0] gain);
    cfg_we    <= 1'b1;
    cfg_index <= mwsm_pkg::REG_SPIN_RATE;
    cfg_data  <= CFG_DATA_W'(spin);
    @(negedge clk);
    cfg_index <= mwsm_pkg::REG_FOLLOW_GAIN;
    cfg_data  <= CFG_DATA_W'(gain);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [SPEED_W-1:0] random_speed();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh8001;
      default: return SPEED_W'($urandom);
    endcase
  endfunction

  // Mostly within minus pi to pi, some near quadrant edges, some any bit pattern.
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int a;
    case ($urandom_range(0, 9))
      7:       a = $urandom;
      8:       a = ($urandom_range(0, 1) ? 16383 : -16384);
      9: begin
        a = $urandom_range(0, 4) * 6434 + $urandom_range(0, 8) - 4;
        if ($urandom_range(0, 1)) a = -a;
      end
      default: a = $urandom_range(0, 25736) - 12868;
    endcase
    return ANGLE_W'(a);
  endfunction

  initial begin : command_stimulus
    logic [SPIN_RATE_W-1:0] spin;
    logic [GAIN_W-1:0]      gain;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = mwsm_pkg::REG_SPIN_RATE;
    cfg_data         = '0;
    cmd.valid        = 1'b0;
    cmd.mode         = mwsm_pkg::MODE_NO_FORCE;
    cmd.speed_x      = '0;
    cmd.speed_y      = '0;
    cmd.gimbal_angle = '0;
    wheels.ready     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed commands under the reset register values: every mode, speed extremes,
    // angles at zero, at the quadrant edges, at plus and minus pi and beyond pi.
    send_command(mwsm_pkg::MODE_NO_FORCE, 16'sd1000, -16'sd2000, 15'sd0);
    send_command(mwsm_pkg::MODE_FOLLOW, 16'sh7fff, 16'sh7fff, 15'sd12868);
    send_command(mwsm_pkg::MODE_ROTATE, 16'sh8000, 16'sh8000, -15'sd12868);
    send_command(mwsm_pkg::MODE_OTHER, 16'sh7fff, 16'sh8000, 15'sd6434);
    send_command(mwsm_pkg::MODE_FOLLOW, 16'sh8000, 16'sh7fff, 15'sh4000);
    send_command(mwsm_pkg::MODE_ROTATE, 16'sd0, 16'sd0, 15'sh3fff);
    send_command(mwsm_pkg::MODE_NO_FORCE, 16'sh8000, 16'sh8000, 15'sh4000);
    send_command(mwsm_pkg::MODE_FOLLOW, 16'sd12345, -16'sd4321, -15'sd1);
    send_command(mwsm_pkg::MODE_OTHER, -16'sd1, 16'sd1, 15'sd1);
    send_command(mwsm_pkg::MODE_ROTATE, 16'sh7fff, 16'sd0, -15'sd6434);
    send_command(mwsm_pkg::MODE_FOLLOW, 16'sd0, 16'sh7fff, 15'sd3217);
    send_command(mwsm_pkg::MODE_NO_FORCE, 16'sh7fff, 16'sh7fff, 15'sd12868);
    send_command(mwsm_pkg::MODE_OTHER, 16'sd0, 16'sd0, 15'sd0);
    send_command(mwsm_pkg::MODE_FOLLOW, -16'sd20000, 16'sd15000, 15'sd9651);
    send_command(mwsm_pkg::MODE_ROTATE, 16'sd5000, 16'sd5000, -15'sd9651);
    send_command(mwsm_pkg::MODE_OTHER, -16'sd32767, 16'sd32767, 15'sd14000);

    // Random phases per register setting: reset values, extremes, random, reset spin with top gain.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_pipeline();
        case (p)
          1:       begin spin = '0;   gain = '0;   end
          2:       begin spin = '1;   gain = '1;   end
          5:       begin spin = mwsm_pkg::SPIN_RATE_RESET; gain = '1; end
          default: begin spin = SPIN_RATE_W'($urandom); gain = GAIN_W'($urandom); end
        endcase
        write_registers(spin, gain);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // Let the pipeline run dry once in the middle of a phase.
        if (p == 3 && i == RANDOM_PER_PHASE / 2) begin
          drain_pipeline();
        end
        send_command(mwsm_pkg::mode_t'($urandom_range(0, 3)), random_speed(),
                     random_speed(), random_angle());
      end
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
